// ----- src/dwps_pkg.sv -----
// Shared widths, reset values, codes and control structs for the wheel speed meter.
`timescale 1ns / 1ps

package dwps_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Configuration register widths
   localparam int MMK_W    = 14;
   localparam int SIGN_W   = 2;
   localparam int LIMIT_W  = 15;
   localparam int TPS_W    = 8;
   localparam int PERIOD_W = 10;

   // Item field widths
   localparam int OPCODE_W = 2;
   localparam int SPD_W    = 15;
   localparam int SEQ_W    = 32;
   localparam int POS_W    = 32;
   localparam int DIST_W   = 36;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   // Divider operand width: sample period and the distance scale both fit
   localparam int DVS_W = PERIOD_W;

   localparam logic [MMK_W-1:0]    MMK_RESET    = MMK_W'(580);
   localparam logic [SIGN_W-1:0]   SIGN_RESET   = SIGN_W'(1);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(2500);
   localparam logic [TPS_W-1:0]    TPS_RESET    = TPS_W'(2);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);
   localparam logic [DVS_W-1:0]    DIST_SCALE   = DVS_W'(1000);

   typedef enum logic [OPCODE_W-1:0] {
      OP_EDGES       = 2'd0,
      OP_TICK        = 2'd1,
      OP_RESET_ALL   = 2'd2,
      OP_RESET_SPEED = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MM_PER_COUNT    = 3'd0,
      CSR_LEFT_SIGN       = 3'd1,
      CSR_RIGHT_SIGN      = 3'd2,
      CSR_SPEED_LIMIT     = 3'd3,
      CSR_TICKS_PER_SAMPLE = 3'd4,
      CSR_SAMPLE_PERIOD   = 3'd5
   } csr_index_type;

   // One multiply-divide pass of the shared divider
   typedef enum logic [1:0] {
      JOB_LEFT_SPEED  = 2'd0,
      JOB_RIGHT_SPEED = 2'd1,
      JOB_LEFT_DIST   = 2'd2,
      JOB_RIGHT_DIST  = 2'd3
   } job_type;

   typedef struct packed {
      logic    accept;
      logic    mul_en;
      logic    div_start;
      logic    store_en;
      logic    publish;
      job_type job;
   } cmd_type;

   typedef struct packed {
      logic sample_now;
      logic div_done;
   } status_type;

endpackage

// ----- src/dwps_if.sv -----
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps

interface dwps_req_if;
   import dwps_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic                left_edge;
   logic                right_edge;

   modport source (output valid, output opcode, output left_edge, output right_edge,
                   input ready);
   modport sink   (input valid, input opcode, input left_edge, input right_edge,
                   output ready);
endinterface

interface dwps_rsp_if;
   import dwps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [SPD_W-1:0]         left_speed;
   logic [SPD_W-1:0]         right_speed;
   logic [SEQ_W-1:0]         sample_seq;
   logic signed [POS_W-1:0]  left_position;
   logic signed [POS_W-1:0]  right_position;
   logic [DIST_W-1:0]        left_distance_mm;
   logic [DIST_W-1:0]        right_distance_mm;

   modport source (output valid, output left_speed, output right_speed, output sample_seq,
                   output left_position, output right_position,
                   output left_distance_mm, output right_distance_mm, input ready);
   modport sink   (input valid, input left_speed, input right_speed, input sample_seq,
                   input left_position, input right_position,
                   input left_distance_mm, input right_distance_mm, output ready);
endinterface

// ----- src/dwps_divider.sv -----
// Iterative restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module dwps_divider #(
   parameter int DIVIDEND_W = dwps_pkg::COUNT_WIDTH_DEFAULT + dwps_pkg::MMK_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIVIDEND_W-1:0]      dividend,
   input  logic [dwps_pkg::DVS_W-1:0] divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);
   import dwps_pkg::*;

   localparam int STEPS  = (DIVIDEND_W + 1) / 2;
   localparam int WORK_W = 2 * STEPS;
   localparam int CNT_W  = $clog2(STEPS + 1);

   // work_ff shifts the dividend out at the top and the quotient in at the bottom
   logic [WORK_W-1:0] work_ff, work_in;
   logic [DVS_W-1:0]  rem_ff, rem_a, rem_b;
   logic [DVS_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DVS_W:0]    trial_a, trial_b;
   logic              q_a, q_b;

   always_comb begin
      trial_a = {rem_ff, work_ff[WORK_W-1]};
      q_a     = trial_a >= {1'b0, dvs_ff};
      rem_a   = q_a ? DVS_W'(trial_a - {1'b0, dvs_ff}) : trial_a[DVS_W-1:0];
      trial_b = {rem_a, work_ff[WORK_W-2]};
      q_b     = trial_b >= {1'b0, dvs_ff};
      rem_b   = q_b ? DVS_W'(trial_b - {1'b0, dvs_ff}) : trial_b[DVS_W-1:0];
      work_in = {work_ff[WORK_W-3:0], q_a, q_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= WORK_W'(dividend);
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_b;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff[DIVIDEND_W-1:0];

endmodule

// ----- src/dwps_datapath.sv -----
// Counters, configuration registers, multiply and divide datapath, response registers.
`timescale 1ns / 1ps

module dwps_datapath #(
   parameter int COUNT_WIDTH = dwps_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dwps_pkg::cmd_type                  cmd,
   output dwps_pkg::status_type               status,
   input  logic [dwps_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic                               req_left_edge,
   input  logic                               req_right_edge,
   input  logic                               csr_write_enable,
   input  logic [dwps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dwps_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output logic [dwps_pkg::SPD_W-1:0]         rsp_left_speed,
   output logic [dwps_pkg::SPD_W-1:0]         rsp_right_speed,
   output logic [dwps_pkg::SEQ_W-1:0]         rsp_sample_seq,
   output logic signed [dwps_pkg::POS_W-1:0]  rsp_left_position,
   output logic signed [dwps_pkg::POS_W-1:0]  rsp_right_position,
   output logic [dwps_pkg::DIST_W-1:0]        rsp_left_distance_mm,
   output logic [dwps_pkg::DIST_W-1:0]        rsp_right_distance_mm
);
   import dwps_pkg::*;

   localparam int PROD_W = COUNT_WIDTH + MMK_W;

   // Configuration
   logic [MMK_W-1:0]    mmk_ff;
   logic [SIGN_W-1:0]   lsign_ff, rsign_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [TPS_W-1:0]    tps_ff;
   logic [PERIOD_W-1:0] period_ff;

   // Wheel state
   logic [COUNT_WIDTH-1:0] lpos_ff, rpos_ff, lfwd_ff, rfwd_ff, lsnap_ff, rsnap_ff;
   logic [SPD_W-1:0]       lfilt_ff, rfilt_ff;
   logic [TPS_W-1:0]       tick_ff, tick_in;
   logic [SEQ_W-1:0]       seq_ff;
   logic [DIST_W-1:0]      ldist_ff, rdist_ff;

   // Multiply and divide
   logic [COUNT_WIDTH-1:0] mul_a;
   logic [DVS_W-1:0]       divisor_in, divisor_ff;
   logic [PERIOD_W-1:0]    period_eff;
   logic [PROD_W-1:0]      prod_ff;
   logic [PROD_W-1:0]      quo;
   logic                   div_done;
   logic [SPD_W-1:0]       raw_speed;
   logic [DIST_W-1:0]      quo_dist;
   logic [COUNT_WIDTH-1:0] lstep, rstep;
   logic [POS_W-1:0]       lpos_out, rpos_out;

   // Response registers
   logic [SPD_W-1:0]        lspd_rsp_ff, rspd_rsp_ff;
   logic [SEQ_W-1:0]        seq_rsp_ff;
   logic [POS_W-1:0]        lpos_rsp_ff, rpos_rsp_ff;
   logic [DIST_W-1:0]       ldist_rsp_ff, rdist_rsp_ff;

   function automatic logic [SPD_W-1:0] filter_next(input logic [SPD_W-1:0] old_val,
                                                    input logic [SPD_W-1:0] raw_val);
      logic [SPD_W+1:0] sum;
      sum = {2'b00, old_val} + {1'b0, raw_val, 1'b0} + {2'b00, raw_val};
      return sum[SPD_W+1:2];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mmk_ff    <= MMK_RESET;
         lsign_ff  <= SIGN_RESET;
         rsign_ff  <= SIGN_RESET;
         limit_ff  <= LIMIT_RESET;
         tps_ff    <= TPS_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MM_PER_COUNT:     mmk_ff    <= csr_write_data[MMK_W-1:0];
            CSR_LEFT_SIGN:        lsign_ff  <= csr_write_data[SIGN_W-1:0];
            CSR_RIGHT_SIGN:       rsign_ff  <= csr_write_data[SIGN_W-1:0];
            CSR_SPEED_LIMIT:      limit_ff  <= csr_write_data[LIMIT_W-1:0];
            CSR_TICKS_PER_SAMPLE: tps_ff    <= csr_write_data[TPS_W-1:0];
            CSR_SAMPLE_PERIOD:    period_ff <= csr_write_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   assign tick_in           = tick_ff + TPS_W'(1);
   assign status.sample_now = (req_opcode == OP_TICK) && (tick_in >= tps_ff);
   assign status.div_done   = div_done;

   assign lstep      = {{(COUNT_WIDTH-SIGN_W){lsign_ff[SIGN_W-1]}}, lsign_ff};
   assign rstep      = {{(COUNT_WIDTH-SIGN_W){rsign_ff[SIGN_W-1]}}, rsign_ff};
   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   always_comb begin
      unique case (cmd.job)
         JOB_LEFT_SPEED: begin
            mul_a      = lfwd_ff - lsnap_ff;
            divisor_in = period_eff;
         end
         JOB_RIGHT_SPEED: begin
            mul_a      = rfwd_ff - rsnap_ff;
            divisor_in = period_eff;
         end
         JOB_LEFT_DIST: begin
            mul_a      = lfwd_ff;
            divisor_in = DIST_SCALE;
         end
         JOB_RIGHT_DIST: begin
            mul_a      = rfwd_ff;
            divisor_in = DIST_SCALE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff    <= PROD_W'(mul_a) * PROD_W'(mmk_ff);
         divisor_ff <= divisor_in;
      end
   end

   dwps_divider #(
      .DIVIDEND_W(PROD_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // Clamp from above at the speed limit
   assign raw_speed = ((|quo[PROD_W-1:SPD_W]) || (quo[SPD_W-1:0] > limit_ff)) ?
                      limit_ff : quo[SPD_W-1:0];

   generate
      if (PROD_W >= DIST_W) begin : g_dist_trunc
         assign quo_dist = quo[DIST_W-1:0];
      end else begin : g_dist_ext
         assign quo_dist = {{(DIST_W-PROD_W){1'b0}}, quo};
      end
      if (COUNT_WIDTH >= POS_W) begin : g_pos_trunc
         assign lpos_out = lpos_ff[POS_W-1:0];
         assign rpos_out = rpos_ff[POS_W-1:0];
      end else begin : g_pos_ext
         assign lpos_out = {{(POS_W-COUNT_WIDTH){1'b0}}, lpos_ff};
         assign rpos_out = {{(POS_W-COUNT_WIDTH){1'b0}}, rpos_ff};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         lpos_ff  <= '0;
         rpos_ff  <= '0;
         lfwd_ff  <= '0;
         rfwd_ff  <= '0;
         lsnap_ff <= '0;
         rsnap_ff <= '0;
         lfilt_ff <= '0;
         rfilt_ff <= '0;
         tick_ff  <= '0;
         seq_ff   <= '0;
      end else begin
         if (cmd.accept) begin
            unique case (opcode_type'(req_opcode))
               OP_EDGES: begin
                  if (req_left_edge) begin
                     lpos_ff <= lpos_ff + lstep;
                     lfwd_ff <= lfwd_ff + COUNT_WIDTH'(1);
                  end
                  if (req_right_edge) begin
                     rpos_ff <= rpos_ff + rstep;
                     rfwd_ff <= rfwd_ff + COUNT_WIDTH'(1);
                  end
               end
               OP_TICK: begin
                  if (status.sample_now) begin
                     tick_ff <= '0;
                     seq_ff  <= seq_ff + SEQ_W'(1);
                  end else begin
                     tick_ff <= tick_in;
                  end
               end
               OP_RESET_ALL: begin
                  lpos_ff  <= '0;
                  rpos_ff  <= '0;
                  lfwd_ff  <= '0;
                  rfwd_ff  <= '0;
                  lsnap_ff <= '0;
                  rsnap_ff <= '0;
                  lfilt_ff <= '0;
                  rfilt_ff <= '0;
                  tick_ff  <= '0;
                  seq_ff   <= '0;
               end
               OP_RESET_SPEED: begin
                  lsnap_ff <= lfwd_ff;
                  rsnap_ff <= rfwd_ff;
                  lfilt_ff <= '0;
                  rfilt_ff <= '0;
                  tick_ff  <= '0;
                  seq_ff   <= '0;
               end
            endcase
         end
         if (cmd.store_en) begin
            unique case (cmd.job)
               JOB_LEFT_SPEED: begin
                  lsnap_ff <= lfwd_ff;
                  lfilt_ff <= filter_next(lfilt_ff, raw_speed);
               end
               JOB_RIGHT_SPEED: begin
                  rsnap_ff <= rfwd_ff;
                  rfilt_ff <= filter_next(rfilt_ff, raw_speed);
               end
               JOB_LEFT_DIST:  ldist_ff <= quo_dist;
               JOB_RIGHT_DIST: rdist_ff <= quo_dist;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         lspd_rsp_ff  <= lfilt_ff;
         rspd_rsp_ff  <= rfilt_ff;
         seq_rsp_ff   <= seq_ff;
         lpos_rsp_ff  <= lpos_out;
         rpos_rsp_ff  <= rpos_out;
         ldist_rsp_ff <= ldist_ff;
         rdist_rsp_ff <= rdist_ff;
      end
   end

   assign rsp_left_speed        = lspd_rsp_ff;
   assign rsp_right_speed       = rspd_rsp_ff;
   assign rsp_sample_seq        = seq_rsp_ff;
   assign rsp_left_position     = lpos_rsp_ff;
   assign rsp_right_position    = rpos_rsp_ff;
   assign rsp_left_distance_mm  = ldist_rsp_ff;
   assign rsp_right_distance_mm = rdist_rsp_ff;

endmodule

// ----- src/dwps_ctrl.sv -----
// Controller state machine: sequences multiply-divide jobs and the response handshake.
`timescale 1ns / 1ps

module dwps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dwps_pkg::status_type status,
   output dwps_pkg::cmd_type    cmd
);
   import dwps_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DSTART,
      S_DWAIT,
      S_STORE,
      S_PUB
   } ctrl_state_type;

   ctrl_state_type state_ff;
   job_type        job_ff;
   logic           rsp_valid_ff;
   logic           out_free;

   function automatic job_type next_job(input job_type job);
      unique case (job)
         JOB_LEFT_SPEED:  return JOB_RIGHT_SPEED;
         JOB_RIGHT_SPEED: return JOB_LEFT_DIST;
         JOB_LEFT_DIST:   return JOB_RIGHT_DIST;
         JOB_RIGHT_DIST:  return JOB_RIGHT_DIST;
      endcase
   endfunction

   // The response register frees up in the same cycle it is taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      cmd.accept    = req_valid && (state_ff == S_IDLE);
      cmd.mul_en    = (state_ff == S_MUL);
      cmd.div_start = (state_ff == S_DSTART);
      cmd.store_en  = (state_ff == S_STORE);
      cmd.publish   = (state_ff == S_PUB) && out_free;
      cmd.job       = job_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= JOB_LEFT_SPEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  // Items without a sample only refresh the distances
                  job_ff   <= status.sample_now ? JOB_LEFT_SPEED : JOB_LEFT_DIST;
                  state_ff <= S_MUL;
               end
            end
            S_MUL:    state_ff <= S_DSTART;
            S_DSTART: state_ff <= S_DWAIT;
            S_DWAIT: begin
               if (status.div_done) begin
                  state_ff <= S_STORE;
               end
            end
            S_STORE: begin
               if (job_ff == JOB_RIGHT_DIST) begin
                  state_ff <= S_PUB;
               end else begin
                  job_ff   <= next_job(job_ff);
                  state_ff <= S_MUL;
               end
            end
            S_PUB: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_publish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while still pending");

   a_accept_blocks_next: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ready)
      else $error("new item taken while one is still in work");

   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_DWAIT))
      else $error("divider finished outside of the wait state");

   a_valid_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("response valid raised without a publish");
`endif

endmodule

// ----- src/dual_wheel_pulse_speed_meter_unit.sv -----
// Top level of the dual wheel pulse speed meter.
// All multiply-divide jobs run through one shared divider.
// An item without a speed sample runs two multiply-divide jobs (distances), a sampling
// tick runs four (two speeds, two distances); each job passes multiply, divider start,
// divider wait and store; a new item is taken only after the last one is published.
// Synchronous active-high reset restores register defaults and clears all counters.
`timescale 1ns / 1ps

module dual_wheel_pulse_speed_meter_unit #(
   parameter int COUNT_WIDTH = dwps_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   dwps_req_if.sink                         req_channel,
   dwps_rsp_if.source                       rsp_channel,
   input  logic                             csr_write_enable,
   input  logic [dwps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dwps_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import dwps_pkg::*;

   cmd_type    cmd;
   status_type status;

   dwps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dwps_datapath #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_opcode            (req_channel.opcode),
      .req_left_edge         (req_channel.left_edge),
      .req_right_edge        (req_channel.right_edge),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_left_speed        (rsp_channel.left_speed),
      .rsp_right_speed       (rsp_channel.right_speed),
      .rsp_sample_seq        (rsp_channel.sample_seq),
      .rsp_left_position     (rsp_channel.left_position),
      .rsp_right_position    (rsp_channel.right_position),
      .rsp_left_distance_mm  (rsp_channel.left_distance_mm),
      .rsp_right_distance_mm (rsp_channel.right_distance_mm)
   );

endmodule
